@@ rtl/core/baro_ins_altitude_fusion_core_macros.svh @@
// Assertion macros for the altitude fusion core.
`ifndef BARO_INS_ALTITUDE_FUSION_CORE_MACROS_SVH
`define BARO_INS_ALTITUDE_FUSION_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BIAF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BIAF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/biaf_pkg.sv @@
// Shared types, constants and the saturation function of the altitude fusion core.
package biaf_pkg;

   localparam int MUL_A_W   = 48;
   localparam int MUL_B_W   = 18;
   localparam int MUL_P_W   = 64;
   localparam int MUL_CNT_W = 5;

   localparam logic [MUL_CNT_W-1:0] NBITS_GAIN = 5'd18;
   localparam logic [MUL_CNT_W-1:0] NBITS_DT   = 5'd16;

   localparam logic [7:0] CSR_WARMUP_ITEMS = 8'd0;
   localparam logic [7:0] CSR_GAIN_ACC     = 8'd1;
   localparam logic [7:0] CSR_GAIN_VEL     = 8'd2;
   localparam logic [7:0] CSR_GAIN_POS     = 8'd3;

   typedef struct packed {
      logic                       start;
      logic signed [MUL_A_W-1:0]  a;
      logic [MUL_B_W-1:0]         b;
      logic [MUL_CNT_W-1:0]       nbits;
   } mul_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd2147483647;
      lo = -64'sd2147483648;
      if (x > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (x < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = x[31:0];
      end
   endfunction

endpackage

@@ rtl/core/baro_ins_altitude_fusion_core.sv @@
// Top level of the barometer and inertial altitude fusion core.
//
//   Channel  Direction  Carries
//   req_     in         baro height, vertical acceleration, elapsed time
//   rsp_     out        fused height and speed, warming flag in tuser
//   csr_     in         register index and write data
//
// A warm-up request goes from acceptance straight to the result stage. A fusion
// request runs the error steps, then eight multiplications through one
// bit-serial shift-add unit with the acceleration step among them, then the
// integration steps; that shared multiplier sets the rate. One request is
// worked at a time. The result register lets the next request be accepted
// while the previous result still waits; a result that cannot be loaded
// stalls the core until the waiting one is taken.
// Reset is synchronous and clears all filter state and restores the register
// defaults.
module baro_ins_altitude_fusion_core #(
   parameter int DELAY_TAPS = 2,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] baro_height, [63:32] accel_vertical, [79:64] delta_time
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] height_estimate, [63:32] speed_estimate
   output logic [63:0] rsp_tdata,
   // [0] warming
   output logic        rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_data
);
   import biaf_pkg::*;

`include "baro_ins_altitude_fusion_core_macros.svh"

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_ERR1   = 10'b0000000010,
      S_ERR2   = 10'b0000000100,
      S_MSTART = 10'b0000001000,
      S_MWAIT  = 10'b0000010000,
      S_MPOST  = 10'b0000100000,
      S_ACC    = 10'b0001000000,
      S_FIN1   = 10'b0010000000,
      S_FIN2   = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   localparam logic signed [63:0] RND_F = 64'sd1 <<< (FRAC_BITS - 1);

   state_type state_ff, state_in;

   // Configuration registers.
   logic [15:0] warmup_items_ff;
   logic [17:0] gain_acc_ff, gain_vel_ff, gain_pos_ff;

   // Filter state.
   logic [15:0]        warmup_count_ff;
   logic signed [31:0] baro_offset_ff, acc_corr_ff, vel_corr_ff, pos_corr_ff;
   logic signed [31:0] prev_accel_ff, curr_accel_ff;
   logic signed [31:0] height_integral_ff, speed_integral_ff;
   logic signed [31:0] speed_out_ff, height_out_ff;
   logic signed [31:0] hist_ff [DELAY_TAPS+1];

   // Per-request working registers.
   logic signed [31:0]        baro_ff, accel_ff, err_ff;
   logic [15:0]               dt_ff;
   logic [2:0]                step_ff;
   logic signed [MUL_A_W-1:0] t1_ff, s_ff, inc_ff;
   logic                      warm_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_height_ff, rsp_speed_ff;
   logic               rsp_warm_ff;

   mul_req_type               mul_req;
   logic                      mul_done;
   logic signed [MUL_P_W-1:0] mul_product;
   logic signed [MUL_P_W-1:0] p_r8, p_rf, p_r9;
   logic signed [31:0]        corr_sel, corr_new;
   logic                      req_fire, warm_now, out_free;

   biaf_serial_mul u_mul (
      .clock       (clock),
      .reset       (reset),
      .mul_req     (mul_req),
      .mul_done    (mul_done),
      .mul_product (mul_product)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign warm_now   = (warmup_count_ff < warmup_items_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Rounded shifts of the product: round to nearest, ties upward.
   assign p_r8 = (mul_product + 64'sd128) >>> 8;
   assign p_rf = (mul_product + RND_F) >>> FRAC_BITS;
   assign p_r9 = (mul_product + 64'sd256) >>> 9;

   // Correction being finished by the odd steps: acc, vel, then pos.
   always_comb begin
      case (step_ff)
         3'd1:    corr_sel = acc_corr_ff;
         3'd3:    corr_sel = vel_corr_ff;
         default: corr_sel = pos_corr_ff;
      endcase
      corr_new = sat32(64'(corr_sel) + p_rf);
   end

   // Operand selection for the shared multiplier, one step at a time.
   always_comb begin
      mul_req.start = (state_ff == S_MSTART);
      case (step_ff)
         3'd0: begin
            mul_req.a = MUL_A_W'(err_ff); mul_req.b = gain_acc_ff;
            mul_req.nbits = NBITS_GAIN;
         end
         3'd2: begin
            mul_req.a = MUL_A_W'(err_ff); mul_req.b = gain_vel_ff;
            mul_req.nbits = NBITS_GAIN;
         end
         3'd4: begin
            mul_req.a = MUL_A_W'(err_ff); mul_req.b = gain_pos_ff;
            mul_req.nbits = NBITS_GAIN;
         end
         3'd6: begin
            mul_req.a = MUL_A_W'(prev_accel_ff) + MUL_A_W'(curr_accel_ff);
            mul_req.b = MUL_B_W'(dt_ff);
            mul_req.nbits = NBITS_DT;
         end
         3'd7: begin
            mul_req.a = (MUL_A_W'(speed_out_ff) <<< 1) + s_ff;
            mul_req.b = MUL_B_W'(dt_ff);
            mul_req.nbits = NBITS_DT;
         end
         default: begin
            mul_req.a = t1_ff; mul_req.b = MUL_B_W'(dt_ff);
            mul_req.nbits = NBITS_DT;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_fire) state_in = warm_now ? S_DONE : S_ERR1;
         S_ERR1:   state_in = S_ERR2;
         S_ERR2:   state_in = S_MSTART;
         S_MSTART: state_in = S_MWAIT;
         S_MWAIT:  if (mul_done) state_in = S_MPOST;
         S_MPOST: begin
            if (step_ff == 3'd5) begin
               state_in = S_ACC;
            end else if (step_ff == 3'd7) begin
               state_in = S_FIN1;
            end else begin
               state_in = S_MSTART;
            end
         end
         S_ACC:    state_in = S_MSTART;
         S_FIN1:   state_in = S_FIN2;
         S_FIN2:   state_in = S_DONE;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         warmup_items_ff    <= 16'd500;
         gain_acc_ff        <= 18'd2427;
         gain_vel_ff        <= 18'd21845;
         gain_pos_ff        <= 18'd65536;
         warmup_count_ff    <= '0;
         baro_offset_ff     <= '0;
         acc_corr_ff        <= '0;
         vel_corr_ff        <= '0;
         pos_corr_ff        <= '0;
         prev_accel_ff      <= '0;
         curr_accel_ff      <= '0;
         height_integral_ff <= '0;
         speed_integral_ff  <= '0;
         speed_out_ff       <= '0;
         height_out_ff      <= '0;
         for (int i = 0; i <= DELAY_TAPS; i++) begin
            hist_ff[i] <= '0;
         end
         rsp_valid_ff       <= 1'b0;
         step_ff            <= '0;
      end else begin
         state_ff <= state_in;

         if (csr_valid) begin
            unique case (csr_index)
               CSR_WARMUP_ITEMS: warmup_items_ff <= csr_data[15:0];
               CSR_GAIN_ACC:     gain_acc_ff     <= csr_data[17:0];
               CSR_GAIN_VEL:     gain_vel_ff     <= csr_data[17:0];
               CSR_GAIN_POS:     gain_pos_ff     <= csr_data[17:0];
               default:          ;
            endcase
         end

         // A new result is loaded as soon as the register is free.
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff) inside
            S_IDLE: begin
               if (req_fire) begin
                  baro_ff  <= req_tdata[31:0];
                  accel_ff <= req_tdata[63:32];
                  dt_ff    <= req_tdata[79:64];
                  warm_ff  <= warm_now;
                  step_ff  <= '0;
                  if (warm_now) begin
                     // Warm-up: clear the corrections and latch the offset.
                     acc_corr_ff     <= '0;
                     vel_corr_ff     <= '0;
                     pos_corr_ff     <= '0;
                     baro_offset_ff  <= req_tdata[31:0];
                     warmup_count_ff <= warmup_count_ff + 16'd1;
                  end
               end
            end
            S_ERR1: err_ff <= sat32(64'(baro_ff) - 64'(baro_offset_ff));
            S_ERR2: err_ff <= sat32(64'(err_ff) - 64'(hist_ff[DELAY_TAPS]));
            S_MSTART, S_MWAIT: ;
            S_MPOST: begin
               case (step_ff) inside
                  3'd0, 3'd2, 3'd4: t1_ff <= p_r8[MUL_A_W-1:0];
                  3'd1: acc_corr_ff <= corr_new;
                  3'd3: vel_corr_ff <= corr_new;
                  3'd5: pos_corr_ff <= corr_new;
                  3'd6: s_ff <= p_r9[MUL_A_W-1:0];
                  default: inc_ff <= p_r9[MUL_A_W-1:0];
               endcase
               if (step_ff != 3'd5 && step_ff != 3'd7) begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            S_ACC: begin
               prev_accel_ff <= curr_accel_ff;
               curr_accel_ff <= sat32(64'(accel_ff) + 64'(acc_corr_ff));
               step_ff       <= 3'd6;
            end
            S_FIN1: begin
               height_integral_ff <= sat32(64'(height_integral_ff) + 64'(inc_ff));
               speed_integral_ff  <= sat32(64'(speed_integral_ff) + 64'(s_ff));
            end
            S_FIN2: begin
               height_out_ff <= sat32(64'(height_integral_ff) + 64'(pos_corr_ff));
               speed_out_ff  <= sat32(64'(speed_integral_ff) + 64'(vel_corr_ff));
               hist_ff[0]    <= sat32(64'(height_integral_ff) + 64'(pos_corr_ff));
               for (int i = 1; i <= DELAY_TAPS; i++) begin
                  hist_ff[i] <= hist_ff[i-1];
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_height_ff <= height_out_ff;
                  rsp_speed_ff  <= speed_out_ff;
                  rsp_warm_ff   <= warm_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_speed_ff, rsp_height_ff};
   assign rsp_tuser  = rsp_warm_ff;

   // A finished multiplication is always picked up in the following cycle.
   `BIAF_ASSERT_NEXT(a_mul_post, (state_ff == S_MWAIT) && mul_done, state_ff == S_MPOST,
      "multiplier result not consumed")
   // A warm-up request goes straight to the result stage.
   `BIAF_ASSERT_NEXT(a_warm_path, req_fire && warm_now, state_ff == S_DONE,
      "warm-up request entered fusion")
   // The newest delay-line tap always follows the fused height.
   `BIAF_ASSERT_NEXT(a_hist_head, state_ff == S_FIN2, hist_ff[0] == height_out_ff,
      "delay line out of step with fused height")

endmodule

@@ rtl/core/biaf_serial_mul.sv @@
// Bit-serial signed by unsigned shift-add multiplier.
module biaf_serial_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  biaf_pkg::mul_req_type              mul_req,
   output logic                               mul_done,
   output logic signed [biaf_pkg::MUL_P_W-1:0] mul_product
);
   import biaf_pkg::*;

   logic                      busy_ff;
   logic                      done_ff;
   logic [MUL_CNT_W-1:0]      cnt_ff;
   logic signed [MUL_P_W-1:0] acc_ff;
   logic signed [MUL_P_W-1:0] a_sh_ff;
   logic [MUL_B_W-1:0]        b_sh_ff;
   logic signed [MUL_P_W-1:0] acc_in;

   // One multiplier bit per cycle, taken from the low end.
   assign acc_in = b_sh_ff[0] ? (acc_ff + a_sh_ff) : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == MUL_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         acc_ff  <= '0;
         a_sh_ff <= MUL_P_W'(mul_req.a);
         b_sh_ff <= mul_req.b;
         cnt_ff  <= mul_req.nbits;
      end else if (busy_ff) begin
         acc_ff  <= acc_in;
         a_sh_ff <= a_sh_ff <<< 1;
         b_sh_ff <= b_sh_ff >> 1;
         cnt_ff  <= cnt_ff - MUL_CNT_W'(1);
      end
   end

   assign mul_done    = done_ff;
   assign mul_product = acc_ff;

endmodule

@@ dv/baro_ins_altitude_fusion_core_test.sv @@
// Self-checking testbench of the barometer and inertial altitude fusion core.
`timescale 1ns / 100ps

module baro_ins_altitude_fusion_core_test;
   import biaf_pkg::*;

   // Register indexes as the core decodes them; one past the last is ignored.
   localparam logic [7:0] CSR_UNUSED = 8'd4;
   localparam int TAPS = 2;
   localparam int FRAC = 16;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic signed [31:0] height;
      logic signed [31:0] speed;
      logic               warming;
   } fused_sample_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [31:0] csr_data;

   baro_ins_altitude_fusion_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Shadow copy of the filter state and registers.
   logic [15:0]        warm_len;
   logic [17:0]        k_acc, k_vel, k_pos;
   logic [15:0]        warm_cnt;
   logic signed [31:0] offset, c_acc, c_vel, c_pos, a_prev, a_curr;
   logic signed [31:0] h_int, v_int, v_out, h_out;
   logic signed [31:0] h_hist [0:TAPS];

   fused_sample_type expected_samples[$];
   int  error_count;
   bit  idle_enabled;
   int  rsp_stall;
   longint cycle_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run ends here if the core hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("baro_ins_altitude_fusion_core_test: errors");
         $finish;
      end
   end

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   // Divide by 2^n, rounding to nearest with ties going up; >>> floors.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
                                                    input int n);
      logic signed [63:0] bias;
      bias = 64'sd1 <<< (n - 1);
      return (x + bias) >>> n;
   endfunction

   function automatic logic signed [31:0] next_corr(input logic signed [31:0] c,
         input logic signed [63:0] e, input logic [17:0] g, input logic [15:0] dt);
      logic signed [63:0] t;
      t = rnd_shift(e * $signed({46'd0, g}), 8);
      t = rnd_shift(t * $signed({48'd0, dt}), FRAC);
      return clamp32(64'(c) + t);
   endfunction

   task automatic reset_shadow();
      warm_len = 16'd500; k_acc = 18'd2427; k_vel = 18'd21845; k_pos = 18'd65536;
      warm_cnt = '0; offset = '0; c_acc = '0; c_vel = '0; c_pos = '0;
      a_prev = '0; a_curr = '0; h_int = '0; v_int = '0; v_out = '0; h_out = '0;
      for (int i = 0; i <= TAPS; i++) h_hist[i] = '0;
   endtask

   // Advances the shadow filter by one request and queues its expected result.
   task automatic predict_fusion(input logic signed [31:0] baro,
                                 input logic signed [31:0] accel,
                                 input logic [15:0] dt);
      logic signed [63:0] err, s, inc, dts;
      fused_sample_type exp_s;
      dts = $signed({48'd0, dt});
      if (warm_cnt < warm_len) begin
         c_acc = '0; c_vel = '0; c_pos = '0;
         offset = baro;
         warm_cnt = warm_cnt + 16'd1;
         exp_s = '{height: h_out, speed: v_out, warming: 1'b1};
      end else begin
         err = 64'(clamp32(64'(baro) - 64'(offset)));
         err = 64'(clamp32(err - 64'(h_hist[TAPS])));
         c_acc = next_corr(c_acc, err, k_acc, dt);
         c_vel = next_corr(c_vel, err, k_vel, dt);
         c_pos = next_corr(c_pos, err, k_pos, dt);
         a_prev = a_curr;
         a_curr = clamp32(64'(accel) + 64'(c_acc));
         s = rnd_shift((64'(a_prev) + 64'(a_curr)) * dts, 9);
         inc = rnd_shift((64'sd2 * 64'(v_out) + s) * dts, 9);
         h_int = clamp32(64'(h_int) + inc);
         h_out = clamp32(64'(h_int) + 64'(c_pos));
         v_int = clamp32(64'(v_int) + s);
         v_out = clamp32(64'(v_int) + 64'(c_vel));
         for (int i = TAPS; i > 0; i--) h_hist[i] = h_hist[i-1];
         h_hist[0] = h_out;
         exp_s = '{height: h_out, speed: v_out, warming: 1'b0};
      end
      expected_samples.push_back(exp_s);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // Drops the request valid for a random burst before the next request.
   task automatic idle_gap();
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Sends one request; the shadow filter advances on acceptance.
   task automatic send_sample(input logic [31:0] baro, input logic [31:0] accel,
                              input logic [15:0] dt);
      idle_gap();
      req_tvalid <= 1'b1;
      req_tdata  <= {dt, accel, baro};
      do @(posedge clock); while (!req_tready);
      predict_fusion(baro, accel, dt);
   endtask

   // Waits until every result is back, plus a margin for work in flight.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // Register write; only called while the core is idle.
   task automatic write_csr(input logic [7:0] idx, input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_WARMUP_ITEMS: warm_len = value[15:0];
         CSR_GAIN_ACC:     k_acc = value[17:0];
         CSR_GAIN_VEL:     k_vel = value[17:0];
         CSR_GAIN_POS:     k_pos = value[17:0];
         default: ;
      endcase
   endtask

   // Result checker with random back-pressure in bursts.
   always @(posedge clock) begin
      fused_sample_type exp_s;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata[31:0], 32'h0);
            end else begin
               exp_s = expected_samples.pop_front();
               if (rsp_tdata[31:0] !== exp_s.height)
                  report_mismatch("height", rsp_tdata[31:0], exp_s.height);
               if (rsp_tdata[63:32] !== exp_s.speed)
                  report_mismatch("speed", rsp_tdata[63:32], exp_s.speed);
               if (rsp_tuser !== exp_s.warming)
                  report_mismatch("warming", {31'd0, rsp_tuser}, {31'd0, exp_s.warming});
            end
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= rsp_stall - 1;
         end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            rsp_stall  <= int'($urandom_range(0, 5));
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      endcase
   endfunction

   task automatic test_warmup_and_extremes();
      write_csr(CSR_WARMUP_ITEMS, 32'd3);
      send_sample(32'h00640000, 32'h0, 16'h0100);
      send_sample(32'h00650000, 32'h0, 16'h0100);
      send_sample(32'h00660000, 32'h0, 16'h0100);
      send_sample(32'h7fffffff, 32'h7fffffff, 16'hffff);
      send_sample(32'h80000000, 32'h80000000, 16'hffff);
      send_sample(32'h7fffffff, 32'h80000000, 16'h0000);
      send_sample(32'h00000000, 32'hffffffff, 16'h0001);
      send_sample(32'h80000000, 32'h7fffffff, 16'h8000);
   endtask

   task automatic test_gain_extremes();
      write_csr(CSR_GAIN_ACC, 32'h3ffff);
      write_csr(CSR_GAIN_VEL, 32'h3ffff);
      write_csr(CSR_GAIN_POS, 32'h3ffff);
      write_csr(CSR_UNUSED, 32'hffffffff);
      for (int i = 0; i < 5; i++) send_sample(rand_word(), rand_word(), 16'hffff);
      write_csr(CSR_GAIN_ACC, 32'h0);
      write_csr(CSR_GAIN_VEL, 32'h0);
      write_csr(CSR_GAIN_POS, 32'h0);
      for (int i = 0; i < 3; i++) send_sample(rand_word(), rand_word(), 16'h0100);
   endtask

   // Raising the warm-up length above the count resumes warm-up.
   task automatic test_warmup_resume();
      write_csr(CSR_WARMUP_ITEMS, {16'hffff, 16'(warm_cnt + 2)});
      for (int i = 0; i < 4; i++) send_sample(rand_word(), rand_word(), 16'h0080);
   endtask

   task automatic test_random_phase(input int count, input logic [15:0] wlen);
      write_csr(CSR_WARMUP_ITEMS, {16'd0, wlen});
      write_csr(CSR_GAIN_ACC, $urandom_range(0, 262143));
      write_csr(CSR_GAIN_VEL, $urandom_range(0, 262143));
      write_csr(CSR_GAIN_POS, $urandom_range(0, 262143));
      for (int i = 0; i < count; i++) begin
         // Mostly plausible flight data, with occasional wild values.
         if ($urandom_range(0, 9) == 0)
            send_sample($urandom, $urandom, 16'($urandom));
         else
            send_sample(32'(warm_cnt) << 16 | 32'($urandom_range(0, 65535)),
                        32'($signed($urandom_range(0, 1300000)) - 650000),
                        16'($urandom_range(64, 1280)));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      error_count = 0; cycle_count = 0; idle_enabled = 1'b1;
      reset_shadow();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero warm-up: fusion starts at once with a zero offset.
      write_csr(CSR_WARMUP_ITEMS, 32'd0);
      send_sample(32'h00010000, 32'h00008000, 16'h0100);
      test_warmup_and_extremes();
      test_gain_extremes();
      test_warmup_resume();
      write_csr(CSR_GAIN_ACC, 32'd2427);
      write_csr(CSR_GAIN_VEL, 32'd21845);
      write_csr(CSR_GAIN_POS, 32'd65536);

      test_random_phase(300, 16'(warm_cnt + 5));
      drain();  // sender holds off until every result has come
      test_random_phase(300, 16'(warm_cnt + 1));
      write_csr(CSR_WARMUP_ITEMS, 32'hffff);
      idle_enabled = 1'b0;
      test_random_phase(200, 16'hffff);

      drain();
      if (error_count == 0) begin
         $display("baro_ins_altitude_fusion_core_test: clean");
      end else begin
         $display("baro_ins_altitude_fusion_core_test: errors");
      end
      $finish;
   end

endmodule

@@ baro_ins_altitude_fusion_core.f @@
+incdir+rtl/core
rtl/core/biaf_pkg.sv
rtl/core/biaf_serial_mul.sv
rtl/core/baro_ins_altitude_fusion_core.sv
dv/baro_ins_altitude_fusion_core_test.sv
